// ----- design/cccv_pkg.sv -----
// shared types, codes and reset values for the cc/cv charge controller
package cccv_pkg;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  // register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHARGE_TARGET  = 3'd0,
    REG_CHARGE_MAX     = 3'd1,
    REG_DISCHARGE      = 3'd2,
    REG_CELL_MIN       = 3'd3,
    REG_CELL_MAX       = 3'd4,
    REG_CHARGE_CURRENT = 3'd5,
    REG_CV_HOLD        = 3'd6,
    REG_CHARGE_ENABLE  = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_CC   = 2'd1,
    MODE_CV   = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_START    = 3'd1,
    EV_ENTER_CV = 3'd2,
    EV_COLD     = 3'd3,
    EV_OVERHEAT = 3'd4,
    EV_TIMEOUT  = 3'd5
  } event_t;

  // reset values of the registers
  localparam logic [9:0]  RST_CHARGE_TARGET  = 10'd588;
  localparam logic [9:0]  RST_CHARGE_MAX     = 10'd588;
  localparam logic [9:0]  RST_DISCHARGE      = 10'd420;
  localparam logic [12:0] RST_CELL_MIN       = 13'd2800;
  localparam logic [12:0] RST_CELL_MAX       = 13'd4200;
  localparam logic [11:0] RST_CHARGE_CURRENT = 12'd0;
  localparam logic [15:0] RST_CV_HOLD        = 16'd7200;

  // current setpoint held while idle, 0.1 A
  localparam logic [11:0] AMP_IDLE = 12'd1;
  // cold derate threshold, 0.1 C
  localparam logic signed [11:0] COLD_DERATE_DC = 12'sd50;
  // 100 * rise > 5 * start  is the same as  20 * rise > start
  localparam logic signed [5:0] RISE_SCALE = 6'sd20;

  typedef struct packed {
    logic [9:0]  charge_target_dv;
    logic [9:0]  charge_max_dv;
    logic [9:0]  discharge_dv;
    logic [12:0] cell_min_mv;
    logic [12:0] cell_max_mv;
    logic [11:0] charge_current_da;
    logic [15:0] cv_hold_s;
    logic        charge_enable;
  } cfg_t;

  typedef struct packed {
    logic [9:0]         pack_dv;
    logic signed [12:0] pack_current_da;
    logic signed [11:0] temp_dc;
    logic [12:0]        max_cell_mv;
    logic [12:0]        min_cell_mv;
    logic [31:0]        now_s;
  } sample_t;

  typedef struct packed {
    logic        charging;
    mode_t       mode;
    logic [9:0]  voltage_setpoint_dv;
    logic [11:0] current_setpoint_da;
    event_t      event_res;
    logic [15:0] cv_remaining_s;
  } result_t;

endpackage

// ----- design/cccv_in_if.sv -----
// sample channel: one periodic check per request
interface cccv_in_if;
  logic               valid;
  logic               ready;
  logic [9:0]         pack_dv;
  logic signed [12:0] pack_current_da;
  logic signed [11:0] temp_dc;
  logic [12:0]        max_cell_mv;
  logic [12:0]        min_cell_mv;
  logic [31:0]        now_s;

  modport source (
    output valid, pack_dv, pack_current_da, temp_dc, max_cell_mv, min_cell_mv, now_s,
    input  ready
  );
  modport sink (
    input  valid, pack_dv, pack_current_da, temp_dc, max_cell_mv, min_cell_mv, now_s,
    output ready
  );
endinterface

// ----- design/cccv_out_if.sv -----
// result channel: charger setpoints and event per check
interface cccv_out_if;
  logic        valid;
  logic        ready;
  logic        charging;
  logic [1:0]  mode;
  logic [9:0]  voltage_setpoint_dv;
  logic [11:0] current_setpoint_da;
  logic [2:0]  event_res;
  logic [15:0] cv_remaining_s;

  modport source (
    output valid, charging, mode, voltage_setpoint_dv, current_setpoint_da, event_res,
           cv_remaining_s,
    input  ready
  );
  modport sink (
    input  valid, charging, mode, voltage_setpoint_dv, current_setpoint_da, event_res,
           cv_remaining_s,
    output ready
  );
endinterface

// ----- design/cccv_core.sv -----
// charge state registers and the per-check update logic
module cccv_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  cccv_pkg::cfg_t    cfg,
  input  cccv_pkg::sample_t item,
  output cccv_pkg::result_t res
);

  logic                  charging;
  cccv_pkg::mode_t       phase;
  logic [9:0]            volt_setpoint;
  logic [11:0]           amp_setpoint;
  logic signed [11:0]    start_temperature;
  logic [31:0]           cv_start;

  logic                  charging_next;
  cccv_pkg::mode_t       phase_next;
  logic [9:0]            volt_setpoint_next;
  logic [11:0]           amp_setpoint_next;
  logic signed [11:0]    start_temperature_next;
  logic [31:0]           cv_start_next;

  logic [11:0]           eff;
  logic [11:0]           cc_limit;
  cccv_pkg::event_t      ev;
  logic [15:0]           remain;
  logic                  entered_cv;
  logic                  stopped;
  logic signed [33:0]    cv_left;
  logic                  cv_due;
  logic signed [17:0]    temp_rise;
  logic signed [17:0]    rise_scaled;
  logic                  overheat;
  logic                  ramp_ok;

  // seconds left to the cv deadline, without wrap
  assign cv_left = $signed({2'b00, cv_start}) + $signed({18'd0, cfg.cv_hold_s})
                 - $signed({2'b00, item.now_s});
  assign cv_due  = cv_left[33] || (cv_left == 34'sd0);

  assign temp_rise   = $signed({{6{item.temp_dc[11]}}, item.temp_dc})
                     - $signed({{6{start_temperature[11]}}, start_temperature});
  assign rise_scaled = temp_rise * 18'(cccv_pkg::RISE_SCALE);
  assign overheat    = rise_scaled > 18'(start_temperature);

  // current limit seen by the cc ramp, derated when cold
  assign cc_limit = ($signed(item.temp_dc) <= cccv_pkg::COLD_DERATE_DC) ? (amp_setpoint >> 2)
                                                                       : amp_setpoint;

  assign ramp_ok = ($signed({item.pack_current_da[12], item.pack_current_da})
                    < $signed({2'b00, cc_limit}))
                && (volt_setpoint < cfg.charge_max_dv);

  always_comb begin
    charging_next          = charging;
    phase_next             = phase;
    volt_setpoint_next     = volt_setpoint;
    amp_setpoint_next      = amp_setpoint;
    start_temperature_next = start_temperature;
    cv_start_next          = cv_start;
    eff                    = amp_setpoint;
    ev                     = cccv_pkg::EV_NONE;
    entered_cv             = 1'b0;
    stopped                = 1'b0;
    remain                 = 16'd0;

    if (charging) begin
      if ($signed(item.temp_dc) <= 12'sd0) begin
        stopped = 1'b1;
        ev      = cccv_pkg::EV_COLD;
      end else begin
        // derate for this check only
        eff = cc_limit;
        if (overheat) begin
          stopped = 1'b1;
          ev      = cccv_pkg::EV_OVERHEAT;
        end else if (phase == cccv_pkg::MODE_CC) begin
          if (item.pack_dv > cfg.charge_target_dv || item.max_cell_mv >= cfg.cell_max_mv) begin
            cv_start_next      = item.now_s;
            phase_next         = cccv_pkg::MODE_CV;
            volt_setpoint_next = cfg.charge_target_dv;
            entered_cv         = 1'b1;
            ev                 = cccv_pkg::EV_ENTER_CV;
          end else if (ramp_ok) begin
            volt_setpoint_next = volt_setpoint + 10'd1;
          end
        end else if (cv_due) begin
          stopped = 1'b1;
          ev      = cccv_pkg::EV_TIMEOUT;
        end
      end
      if (stopped) begin
        charging_next      = 1'b0;
        phase_next         = cccv_pkg::MODE_IDLE;
        amp_setpoint_next  = cccv_pkg::AMP_IDLE;
        volt_setpoint_next = cfg.charge_target_dv;
        eff                = cccv_pkg::AMP_IDLE;
      end
    end else if ((item.pack_dv < cfg.discharge_dv || item.min_cell_mv <= cfg.cell_min_mv)
                 && cfg.charge_enable) begin
      charging_next          = 1'b1;
      phase_next             = cccv_pkg::MODE_CC;
      volt_setpoint_next     = cfg.charge_target_dv;
      amp_setpoint_next      = cfg.charge_current_da;
      start_temperature_next = item.temp_dc;
      eff                    = cfg.charge_current_da;
      ev                     = cccv_pkg::EV_START;
    end

    // a continuing cv check is known to be short of its deadline
    if (charging_next && phase_next == cccv_pkg::MODE_CV) begin
      if (entered_cv) begin
        remain = cfg.cv_hold_s;
      end else if (|cv_left[32:16]) begin
        remain = 16'hFFFF;
      end else begin
        remain = cv_left[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      charging          <= 1'b0;
      phase             <= cccv_pkg::MODE_IDLE;
      volt_setpoint     <= cccv_pkg::RST_CHARGE_TARGET;
      amp_setpoint      <= cccv_pkg::AMP_IDLE;
      start_temperature <= 12'sd0;
      cv_start          <= 32'd0;
    end else if (step) begin
      charging          <= charging_next;
      phase             <= phase_next;
      volt_setpoint     <= volt_setpoint_next;
      amp_setpoint      <= amp_setpoint_next;
      start_temperature <= start_temperature_next;
      cv_start          <= cv_start_next;
    end
  end

  assign res.charging            = charging_next;
  assign res.mode                = charging_next ? phase_next : cccv_pkg::MODE_IDLE;
  assign res.voltage_setpoint_dv = volt_setpoint_next;
  assign res.current_setpoint_da = eff;
  assign res.event_res           = ev;
  assign res.cv_remaining_s      = remain;

  a_idle_phase: assert property (@(posedge clk) disable iff (rst)
    !charging |-> phase == cccv_pkg::MODE_IDLE)
    else $error("phase set while not charging");

  a_idle_amp: assert property (@(posedge clk) disable iff (rst)
    !charging |-> amp_setpoint == cccv_pkg::AMP_IDLE)
    else $error("current setpoint not at idle value");

  a_cv_latch: assert property (@(posedge clk) disable iff (rst)
    step && entered_cv |=> cv_start == $past(item.now_s))
    else $error("cv start time not captured");

endmodule

// ----- design/cc_cv_charge_controller.sv -----
// CC/CV charge controller top level: configuration, input and result registers
// Each request is one periodic check of pack voltage, current, temperature and
// cell extremes; it yields one result with the charger setpoints, the mode and
// an event code. One request is taken every clock cycle unless a stalled result keeps
// the input register full; a result is presented once its request has passed the input
// register and then the result register, as the whole charge state update is a single
// pass of compare logic between them. A stalled result holds one further request in the
// input register. Configuration is read live and should be written only while no check
// is in flight.
module cc_cv_charge_controller (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [cccv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cccv_pkg::CFG_DATA_W-1:0]  cfg_data,
  cccv_in_if.sink                          sample,
  cccv_out_if.source                       result
);

  cccv_pkg::cfg_t    cfg;
  cccv_pkg::sample_t s1;
  logic              s1_valid;
  cccv_pkg::result_t res_comb;
  cccv_pkg::result_t res;
  logic              res_valid;
  logic              advance;
  logic              take;

  assign advance      = s1_valid && (!res_valid || result.ready);
  assign sample.ready = !s1_valid || advance;
  assign take         = sample.valid && sample.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.charge_target_dv  <= cccv_pkg::RST_CHARGE_TARGET;
      cfg.charge_max_dv     <= cccv_pkg::RST_CHARGE_MAX;
      cfg.discharge_dv      <= cccv_pkg::RST_DISCHARGE;
      cfg.cell_min_mv       <= cccv_pkg::RST_CELL_MIN;
      cfg.cell_max_mv       <= cccv_pkg::RST_CELL_MAX;
      cfg.charge_current_da <= cccv_pkg::RST_CHARGE_CURRENT;
      cfg.cv_hold_s         <= cccv_pkg::RST_CV_HOLD;
      cfg.charge_enable     <= 1'b0;
    end else if (cfg_we) begin
      case (cccv_pkg::cfg_reg_t'(cfg_index))
        cccv_pkg::REG_CHARGE_TARGET:  cfg.charge_target_dv  <= cfg_data[9:0];
        cccv_pkg::REG_CHARGE_MAX:     cfg.charge_max_dv     <= cfg_data[9:0];
        cccv_pkg::REG_DISCHARGE:      cfg.discharge_dv      <= cfg_data[9:0];
        cccv_pkg::REG_CELL_MIN:       cfg.cell_min_mv       <= cfg_data[12:0];
        cccv_pkg::REG_CELL_MAX:       cfg.cell_max_mv       <= cfg_data[12:0];
        cccv_pkg::REG_CHARGE_CURRENT: cfg.charge_current_da <= cfg_data[11:0];
        cccv_pkg::REG_CV_HOLD:        cfg.cv_hold_s         <= cfg_data[15:0];
        cccv_pkg::REG_CHARGE_ENABLE:  cfg.charge_enable     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1.pack_dv         <= sample.pack_dv;
      s1.pack_current_da <= sample.pack_current_da;
      s1.temp_dc         <= sample.temp_dc;
      s1.max_cell_mv     <= sample.max_cell_mv;
      s1.min_cell_mv     <= sample.min_cell_mv;
      s1.now_s           <= sample.now_s;
    end
  end

  cccv_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .cfg  (cfg),
    .item (s1),
    .res  (res_comb)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_comb;
    end
  end

  assign result.valid               = res_valid;
  assign result.charging            = res.charging;
  assign result.mode                = res.mode;
  assign result.voltage_setpoint_dv = res.voltage_setpoint_dv;
  assign result.current_setpoint_da = res.current_setpoint_da;
  assign result.event_res           = res.event_res;
  assign result.cv_remaining_s      = res.cv_remaining_s;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && res_valid && !result.ready |=> s1_valid)
    else $error("pending request lost under stall");

  a_mode_flag: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.charging == (res.mode != cccv_pkg::MODE_IDLE)))
    else $error("mode disagrees with charging flag");

  a_start_cc: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.event_res == cccv_pkg::EV_START |-> res.mode == cccv_pkg::MODE_CC)
    else $error("start event outside cc mode");

  a_remain_cv: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.cv_remaining_s != 16'd0 |-> res.mode == cccv_pkg::MODE_CV)
    else $error("cv time left outside cv mode");

endmodule

// ----- dv/tb.sv -----
// self-checking testbench for the cc/cv charge controller, with its own charge-state predictor
`timescale 1ns / 1ps

module tb;

  localparam int LIMIT_CYCLES = 300000;
  localparam int DRAIN_CYCLES = 4;
  localparam int COLD_DC      = 50;

  logic                            clk;
  logic                            rst;
  logic                            cfg_we;
  logic [cccv_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [cccv_pkg::CFG_DATA_W-1:0] cfg_data;

  cccv_in_if  sample_ch ();
  cccv_out_if result_ch ();

  cc_cv_charge_controller dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_ch),
    .result    (result_ch)
  );

  // predicted charge state and live register copy
  cccv_pkg::cfg_t    charge_cfg;
  logic              chg_active;
  cccv_pkg::mode_t   chg_phase;
  logic [9:0]        volt_sp;
  logic [11:0]       amp_sp;
  int                temp_at_start;
  logic [31:0]       cv_began;

  cccv_pkg::result_t charger_out_q[$];
  cccv_pkg::result_t want_out;
  int                errors = 0;
  int                cycles = 0;
  int                hold_off = 0;
  bit                send_gaps = 1;
  bit                recv_gaps = 1;
  logic [31:0]       sim_now = '0;
  int                base_temp = 250;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic flag_mismatch(string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  function automatic void reset_model();
    charge_cfg.charge_target_dv  = cccv_pkg::RST_CHARGE_TARGET;
    charge_cfg.charge_max_dv     = cccv_pkg::RST_CHARGE_MAX;
    charge_cfg.discharge_dv      = cccv_pkg::RST_DISCHARGE;
    charge_cfg.cell_min_mv       = cccv_pkg::RST_CELL_MIN;
    charge_cfg.cell_max_mv       = cccv_pkg::RST_CELL_MAX;
    charge_cfg.charge_current_da = cccv_pkg::RST_CHARGE_CURRENT;
    charge_cfg.cv_hold_s         = cccv_pkg::RST_CV_HOLD;
    charge_cfg.charge_enable     = 1'b0;
    chg_active    = 1'b0;
    chg_phase     = cccv_pkg::MODE_IDLE;
    volt_sp       = cccv_pkg::RST_CHARGE_TARGET;
    amp_sp        = cccv_pkg::AMP_IDLE;
    temp_at_start = 0;
    cv_began      = '0;
  endfunction

  function automatic void end_cycle();
    chg_active = 1'b0;
    chg_phase  = cccv_pkg::MODE_IDLE;
    amp_sp     = cccv_pkg::AMP_IDLE;
    volt_sp    = charge_cfg.charge_target_dv;
  endfunction

  function automatic cccv_pkg::result_t next_charger_out(cccv_pkg::sample_t s);
    cccv_pkg::result_t r;
    int                temp;
    int                amps;
    logic [11:0]       eff;
    logic [32:0]       deadline;
    logic [32:0]       left;
    cccv_pkg::event_t  ev;
    temp = int'($signed(s.temp_dc));
    amps = int'($signed(s.pack_current_da));
    ev   = cccv_pkg::EV_NONE;
    eff  = amp_sp;
    left = '0;
    if (chg_active) begin
      if (temp <= 0) begin
        end_cycle();
        ev = cccv_pkg::EV_COLD;
      end else begin
        // cold derate holds for this check only
        if (temp <= COLD_DC) eff = amp_sp >> 2;
        if (longint'(temp - temp_at_start) * 100 > longint'(temp_at_start) * 5) begin
          end_cycle();
          ev = cccv_pkg::EV_OVERHEAT;
        end else if (chg_phase == cccv_pkg::MODE_CC) begin
          if (s.pack_dv > charge_cfg.charge_target_dv ||
              s.max_cell_mv >= charge_cfg.cell_max_mv) begin
            cv_began  = s.now_s;
            chg_phase = cccv_pkg::MODE_CV;
            volt_sp   = charge_cfg.charge_target_dv;
            ev        = cccv_pkg::EV_ENTER_CV;
          end else if (amps < int'(eff) && volt_sp < charge_cfg.charge_max_dv) begin
            volt_sp = volt_sp + 10'd1;
          end
        end else begin
          deadline = 33'(cv_began) + 33'(charge_cfg.cv_hold_s);
          if (33'(s.now_s) >= deadline) begin
            end_cycle();
            ev = cccv_pkg::EV_TIMEOUT;
          end
        end
      end
      if (!chg_active) eff = amp_sp;
    end else if (s.pack_dv < charge_cfg.discharge_dv ||
                 s.min_cell_mv <= charge_cfg.cell_min_mv) begin
      if (charge_cfg.charge_enable) begin
        chg_active    = 1'b1;
        chg_phase     = cccv_pkg::MODE_CC;
        volt_sp       = charge_cfg.charge_target_dv;
        amp_sp        = charge_cfg.charge_current_da;
        temp_at_start = temp;
        eff           = amp_sp;
        ev            = cccv_pkg::EV_START;
      end
    end
    if (chg_active && chg_phase == cccv_pkg::MODE_CV) begin
      // deadline kept at 33 bits so it never wraps
      deadline = 33'(cv_began) + 33'(charge_cfg.cv_hold_s);
      if (deadline > 33'(s.now_s)) left = deadline - 33'(s.now_s);
      if (left > 33'hFFFF) left = 33'hFFFF;
    end
    r.charging            = chg_active;
    r.mode                = chg_active ? chg_phase : cccv_pkg::MODE_IDLE;
    r.voltage_setpoint_dv = volt_sp;
    r.current_setpoint_da = eff;
    r.event_res           = ev;
    r.cv_remaining_s      = left[15:0];
    return r;
  endfunction

  task automatic write_reg(cccv_pkg::cfg_reg_t idx, logic [cccv_pkg::CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = v;
    @(posedge clk);
    case (idx)
      cccv_pkg::REG_CHARGE_TARGET:  charge_cfg.charge_target_dv  = v[9:0];
      cccv_pkg::REG_CHARGE_MAX:     charge_cfg.charge_max_dv     = v[9:0];
      cccv_pkg::REG_DISCHARGE:      charge_cfg.discharge_dv      = v[9:0];
      cccv_pkg::REG_CELL_MIN:       charge_cfg.cell_min_mv       = v[12:0];
      cccv_pkg::REG_CELL_MAX:       charge_cfg.cell_max_mv       = v[12:0];
      cccv_pkg::REG_CHARGE_CURRENT: charge_cfg.charge_current_da = v[11:0];
      cccv_pkg::REG_CV_HOLD:        charge_cfg.cv_hold_s         = v[15:0];
      cccv_pkg::REG_CHARGE_ENABLE:  charge_cfg.charge_enable     = v[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_config(int tgt, int mx, int dis, int cmin, int cmax, int cur,
                             int hold, int en);
    write_reg(cccv_pkg::REG_CHARGE_TARGET, 16'(tgt));
    write_reg(cccv_pkg::REG_CHARGE_MAX, 16'(mx));
    write_reg(cccv_pkg::REG_DISCHARGE, 16'(dis));
    write_reg(cccv_pkg::REG_CELL_MIN, 16'(cmin));
    write_reg(cccv_pkg::REG_CELL_MAX, 16'(cmax));
    write_reg(cccv_pkg::REG_CHARGE_CURRENT, 16'(cur));
    write_reg(cccv_pkg::REG_CV_HOLD, 16'(hold));
    write_reg(cccv_pkg::REG_CHARGE_ENABLE, 16'(en));
  endtask

  // one request: random gap, then hold until the block takes it
  task automatic send_check(cccv_pkg::sample_t s);
    @(negedge clk);
    while (send_gaps && $urandom_range(99) < 16) begin
      sample_ch.valid = 1'b0;
      @(negedge clk);
    end
    sample_ch.valid           = 1'b1;
    sample_ch.pack_dv         = s.pack_dv;
    sample_ch.pack_current_da = s.pack_current_da;
    sample_ch.temp_dc         = s.temp_dc;
    sample_ch.max_cell_mv     = s.max_cell_mv;
    sample_ch.min_cell_mv     = s.min_cell_mv;
    sample_ch.now_s           = s.now_s;
    do @(posedge clk); while (!sample_ch.ready);
    charger_out_q.push_back(next_charger_out(s));
  endtask

  task automatic send_fields(int pack, int amps, int temp, int cmax, int cmin,
                             logic [31:0] now);
    cccv_pkg::sample_t s;
    s.pack_dv         = 10'(pack);
    s.pack_current_da = 13'(amps);
    s.temp_dc         = 12'(temp);
    s.max_cell_mv     = 13'(cmax);
    s.min_cell_mv     = 13'(cmin);
    s.now_s           = now;
    send_check(s);
  endtask

  task automatic settle();
    @(negedge clk);
    sample_ch.valid = 1'b0;
    while (charger_out_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // mostly plausible charge traffic against the live thresholds, some noise
  function automatic cccv_pkg::sample_t make_check();
    cccv_pkg::sample_t s;
    int                t;
    int                p;
    if ($urandom_range(99) < 15) begin
      // noise: voltage and current anything the fields allow, time may step back
      s.pack_dv         = 10'($urandom);
      s.pack_current_da = 13'($urandom);
      s.temp_dc         = 12'(int'($urandom_range(1650)) - 400);
      s.max_cell_mv     = 13'($urandom_range(5000));
      s.min_cell_mv     = 13'($urandom_range(5000));
      s.now_s           = $urandom;
      return s;
    end
    sim_now = sim_now + (($urandom_range(49) == 0) ? $urandom_range(100000)
                                                   : $urandom_range(3));
    case ($urandom_range(9))
      0, 1, 2: p = $urandom_range(charge_cfg.discharge_dv);
      9:       p = $urandom_range(1023, charge_cfg.charge_target_dv);
      default: p = $urandom_range(charge_cfg.charge_target_dv);
    endcase
    case ($urandom_range(39))
      0:       t = int'($urandom_range(400)) - 400;
      1:       t = base_temp + base_temp / 10 + 1 + $urandom_range(20);
      default: t = base_temp + $urandom_range(base_temp / 20);
    endcase
    s.pack_dv = 10'(p);
    s.temp_dc = 12'(t);
    s.now_s   = sim_now;
    if ($urandom_range(1)) s.pack_current_da = 13'($urandom_range(charge_cfg.charge_current_da));
    else s.pack_current_da = 13'($urandom);
    if ($urandom_range(9) == 0)
      s.max_cell_mv = 13'($urandom_range(5000, charge_cfg.cell_max_mv));
    else s.max_cell_mv = 13'($urandom_range(charge_cfg.cell_max_mv));
    if ($urandom_range(9) < 3) s.min_cell_mv = 13'($urandom_range(charge_cfg.cell_min_mv));
    else s.min_cell_mv = 13'($urandom_range(5000, charge_cfg.cell_min_mv));
    return s;
  endfunction

  task automatic run_checks(int n);
    // low starting temperatures exercise the cold derate
    if ($urandom_range(9) < 3) base_temp = $urandom_range(COLD_DC, 1);
    else base_temp = $urandom_range(1000, COLD_DC + 1);
    repeat (n) send_check(make_check());
  endtask

  // result side: random stalls plus an optional long hold-off
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        result_ch.ready = 1'b0;
        hold_off--;
      end else if (recv_gaps && $urandom_range(99) < 16) begin
        result_ch.ready = 1'b0;
      end else begin
        result_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (charger_out_q.size() == 0) begin
        flag_mismatch("result with no request outstanding");
      end else begin
        want_out = charger_out_q.pop_front();
        if (result_ch.charging !== want_out.charging)
          flag_mismatch($sformatf("charging got %0d want %0d",
                                  result_ch.charging, want_out.charging));
        if (result_ch.mode !== want_out.mode)
          flag_mismatch($sformatf("mode got %0d want %0d", result_ch.mode, want_out.mode));
        if (result_ch.voltage_setpoint_dv !== want_out.voltage_setpoint_dv)
          flag_mismatch($sformatf("voltage setpoint got %0d want %0d",
                                  result_ch.voltage_setpoint_dv, want_out.voltage_setpoint_dv));
        if (result_ch.current_setpoint_da !== want_out.current_setpoint_da)
          flag_mismatch($sformatf("current setpoint got %0d want %0d",
                                  result_ch.current_setpoint_da, want_out.current_setpoint_da));
        if (result_ch.event_res !== want_out.event_res)
          flag_mismatch($sformatf("event got %0d want %0d",
                                  result_ch.event_res, want_out.event_res));
        if (result_ch.cv_remaining_s !== want_out.cv_remaining_s)
          flag_mismatch($sformatf("cv remaining got %0d want %0d",
                                  result_ch.cv_remaining_s, want_out.cv_remaining_s));
      end
    end
  end

  task automatic test_idle_defaults();
    // charging disabled out of reset: no start even when the pack is flat
    send_fields(0, -4096, -400, 0, 0, 32'd0);
    send_fields(1023, 4095, 1250, 5000, 5000, 32'hFFFF_FFFF);
  endtask

  task automatic test_charge_cycle();
    settle();
    load_config(600, 603, 500, 3000, 4150, 200, 5, 1);
    send_fields(450, 100, 250, 4000, 3500, 32'd100);   // start on low pack
    send_fields(550, 100, 250, 4000, 3500, 32'd101);   // ramp
    send_fields(550, 300, 255, 4000, 3500, 32'd102);   // current above limit, hold
    send_fields(550, -5, 262, 4000, 3500, 32'd103);    // rise just under 5 percent
    send_fields(550, 0, 260, 4000, 3500, 32'd104);
    send_fields(550, 0, 260, 4000, 3500, 32'd105);     // at ceiling
    send_fields(601, 0, 260, 4000, 3500, 32'd106);     // enter cv on pack
    send_fields(550, 0, 260, 4000, 3500, 32'd110);
    send_fields(550, 0, 260, 4000, 3500, 32'd111);     // hold timer runs out
    send_fields(700, 0, 250, 4000, 3000, 32'd200);     // start on lowest cell
    send_fields(550, 0, 263, 4000, 3500, 32'd201);     // overheat
    send_fields(700, 0, 40, 4000, 2000, 32'd300);      // cold start
    send_fields(550, 10, 42, 4000, 3500, 32'd301);     // derated limit, ramp
    send_fields(550, 60, 41, 4000, 3500, 32'd302);     // derated limit blocks ramp
    send_fields(550, 0, 40, 4150, 3500, 32'd303);      // enter cv on highest cell
    send_fields(550, 0, 0, 4000, 3500, 32'd304);       // cold stop at 0 C
    send_fields(400, 0, -10, 4000, 3500, 32'd400);     // start below freezing
    send_fields(400, 0, 5, 4000, 3500, 32'd401);       // any warm check overheats
  endtask

  task automatic test_long_cv_hold();
    settle();
    write_reg(cccv_pkg::REG_CV_HOLD, 16'hFFFF);
    send_fields(400, 0, 300, 4000, 3500, 32'hFFFF_0000);
    send_fields(650, 0, 300, 4000, 3500, 32'hFFFF_FFF0);  // deadline past 32 bits
    send_fields(550, 0, 300, 4000, 3500, 32'hFFFF_FFFF);
    send_fields(550, 0, 300, 4000, 3500, 32'd0);          // clock steps back, saturates
  endtask

  task automatic test_config_extremes();
    settle();
    load_config(0, 0, 0, 0, 0, 0, 0, 1);
    run_checks(40);
    settle();
    load_config(1023, 1023, 1023, 5000, 5000, 4095, 65535, 1);
    run_checks(40);
  endtask

  task automatic test_random_charging();
    int tgt;
    repeat (4) begin
      settle();
      tgt = $urandom_range(800, 300);
      load_config(tgt, (tgt + $urandom_range(30) > 1023) ? 1023 : tgt + $urandom_range(30),
                  $urandom_range(tgt), $urandom_range(3300, 2500), $urandom_range(4300, 3900),
                  $urandom_range(4095),
                  ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(40),
                  ($urandom_range(9) != 0));
      run_checks(60);
    end
  endtask

  task automatic test_no_idling();
    send_gaps = 0;
    recv_gaps = 0;
    run_checks(60);
    send_gaps = 1;
    recv_gaps = 1;
  endtask

  task automatic test_input_backpressure();
    // results held back while requests keep coming, so the input stalls
    send_gaps = 0;
    hold_off  = 80;
    run_checks(40);
    send_gaps = 1;
  endtask

  initial begin
    rst                       = 1'b1;
    cfg_we                    = 1'b0;
    cfg_index                 = cccv_pkg::REG_CHARGE_TARGET;
    cfg_data                  = '0;
    sample_ch.valid           = 1'b0;
    sample_ch.pack_dv         = '0;
    sample_ch.pack_current_da = '0;
    sample_ch.temp_dc         = '0;
    sample_ch.max_cell_mv     = '0;
    sample_ch.min_cell_mv     = '0;
    sample_ch.now_s           = '0;
    reset_model();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_idle_defaults();
    test_charge_cycle();
    test_long_cv_hold();
    test_config_extremes();
    test_random_charging();
    test_no_idling();
    test_input_backpressure();
    settle();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/cccv_pkg.sv
design/cccv_in_if.sv
design/cccv_out_if.sv
design/cccv_core.sv
design/cc_cv_charge_controller.sv
dv/tb.sv
